// ===== rtl/gvis_pkg.sv =====
// ----------------------------------------------------------------------------
// gvis_pkg
// Shared constants and types of the g-vector indexing score block.
// ----------------------------------------------------------------------------
package gvis_pkg;

  localparam int unsigned G_WIDTH_DEF     = 24;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned ENTRY_W    = 20;
  localparam int unsigned ROW_W      = 3 * ENTRY_W;
  localparam int unsigned TOL_W      = 32;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned RESID_W    = 16;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = ROW_W;

  localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_ROW0 = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_ROW1 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_ROW2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL_SQ      = 2'd3;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ===== rtl/gvis_row.sv =====
// ----------------------------------------------------------------------------
// gvis_row
// One matrix row: products, fractional part, rounded residual, square.
// ----------------------------------------------------------------------------
module gvis_row #(
  parameter int unsigned G_WIDTH = gvis_pkg::G_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  gvis_pkg::stage_en_t               en_i,
  input  logic [gvis_pkg::ROW_W-1:0]        row_i,
  input  logic signed [G_WIDTH-1:0]         gx_i,
  input  logic signed [G_WIDTH-1:0]         gy_i,
  input  logic signed [G_WIDTH-1:0]         gz_i,
  output logic [gvis_pkg::SQ_W-1:0]         sq_o
);

  localparam int unsigned FRAC_W = G_WIDTH + 8;
  localparam int unsigned PROD_W = gvis_pkg::ENTRY_W + G_WIDTH;
  localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1) << (FRAC_W - 1);
  localparam logic [FRAC_W-1:0] RND  = FRAC_W'(1) << (FRAC_W - 17);

  logic signed [gvis_pkg::ENTRY_W-1:0] ent [3];
  logic signed [G_WIDTH-1:0]           g   [3];
  logic signed [PROD_W-1:0]            prod [3];
  logic [FRAC_W-1:0]                   prod_q [3];
  logic [FRAC_W-1:0]                   frac_d, frac_q;
  logic [FRAC_W-1:0]                   mag, rsum;
  logic [gvis_pkg::RESID_W-1:0]        resid_d, resid_q;
  logic [gvis_pkg::SQ_W-1:0]           sq_d, sq_q;

  assign g[0] = gx_i;
  assign g[1] = gy_i;
  assign g[2] = gz_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ent[c]  = row_i[gvis_pkg::ENTRY_W*c +: gvis_pkg::ENTRY_W];
      prod[c] = PROD_W'(ent[c]) * PROD_W'(g[c]);
    end
  end

  assign frac_d  = prod_q[0] + prod_q[1] + prod_q[2];
  assign mag     = (frac_q <= HALF) ? frac_q : (~frac_q + FRAC_W'(1));
  assign rsum    = mag + RND;
  assign resid_d = rsum[FRAC_W-1 -: gvis_pkg::RESID_W];
  assign sq_d    = gvis_pkg::SQ_W'(resid_q) * gvis_pkg::SQ_W'(resid_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= prod[c][FRAC_W-1:0];
      end
    end
    if (en_i.s2) begin
      frac_q <= frac_d;
    end
    if (en_i.s3) begin
      resid_q <= resid_d;
    end
    if (en_i.s4) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== rtl/gvis_score.sv =====
// ----------------------------------------------------------------------------
// gvis_score
// Tolerance compare, saturating count and registered result output.
// ----------------------------------------------------------------------------
module gvis_score #(
  parameter int unsigned COUNT_WIDTH = gvis_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       last_i,
  input  logic [gvis_pkg::SQ_W-1:0]  sq_i [3],
  input  logic [gvis_pkg::TOL_W-1:0] tol_i,
  output logic                       ready_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [gvis_pkg::OUT_W-1:0] m_tdata_o
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [gvis_pkg::SQ_W-1:0]         sum;
  logic                              hit_q, last_q, valid_q;
  logic                              consume, emit;
  logic [COUNT_WIDTH-1:0]            cnt_q, cnt_d, cnt_inc;
  logic [COUNT_WIDTH+gvis_pkg::OUT_W-1:0] cnt_ext;
  logic                              out_valid_q, out_valid_d;
  logic [gvis_pkg::OUT_W-1:0]        out_data_q;

  assign sum     = sq_i[0] + sq_i[1] + sq_i[2];
  assign consume = valid_q && (!last_q || !out_valid_q || m_tready_i);
  assign emit    = consume && last_q;
  assign ready_o = !valid_q || consume;

  assign cnt_inc = (hit_q && cnt_q != CNT_MAX) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
  assign cnt_ext = {{gvis_pkg::OUT_W{1'b0}}, cnt_inc};

  always_comb begin
    cnt_d = cnt_q;
    if (consume) begin
      cnt_d = last_q ? '0 : cnt_inc;
    end
  end

  assign out_valid_d = (out_valid_q && !m_tready_i) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      hit_q  <= sum < tol_i;
      last_q <= last_i;
    end
    if (emit) begin
      out_data_q <= cnt_ext[gvis_pkg::OUT_W-1:0];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_clear_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> cnt_q == '0)
    else $error("count not cleared after result");

  a_count_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_MAX && !emit) |=> cnt_q == CNT_MAX)
    else $error("count wrapped past maximum");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (out_valid_q && !m_tready_i && last_q))
    else $error("score stage stalled without a blocked result");

  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result lost");
`endif

endmodule

// ===== rtl/gvector_index_score.sv =====
// ----------------------------------------------------------------------------
// gvector_index_score
// Indexing score of a stream of scattering vectors against an orientation.
// ----------------------------------------------------------------------------
// Each vector is multiplied by the configured 3x3 matrix, the distance of
// h, k and l to the nearest integer is rounded to Q0.16, squared and summed,
// and the vector counts when that sum is strictly below tol_sq. The vector
// with tlast closes a set: the count including it is sent as one result
// transaction and cleared. One vector is accepted per clock, but acceptance
// stalls while a closing vector waits at the compare stage behind a result
// not yet taken. A closing vector passes four arithmetic stages (the first
// holding the nine registered multiplier products), the compare stage and
// the output register, the first loaded at the edge that accepts it. Non-closing vectors keep
// flowing while a result waits. Write the configuration only while idle.
module gvector_index_score #(
  parameter int unsigned G_WIDTH     = gvis_pkg::G_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = gvis_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gvis_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [gvis_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // gx, gy, gz
  input  logic [((3*G_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // indexed_count
  output logic [gvis_pkg::OUT_W-1:0]       m_axis_tdata
);

  logic [gvis_pkg::ROW_W-1:0] row_q [3];
  logic [gvis_pkg::TOL_W-1:0] tol_q;

  logic signed [G_WIDTH-1:0]  gx, gy, gz;
  logic [3:0]                 valid_q;
  logic [3:0]                 last_q;
  logic [4:0]                 ld;
  logic                       score_ready;
  gvis_pkg::stage_en_t        en;
  logic [gvis_pkg::SQ_W-1:0]  sq [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= '0;
      row_q[1] <= '0;
      row_q[2] <= '0;
      tol_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gvis_pkg::REG_MATRIX_ROW0: row_q[0] <= cfg_wdata_i;
        gvis_pkg::REG_MATRIX_ROW1: row_q[1] <= cfg_wdata_i;
        gvis_pkg::REG_MATRIX_ROW2: row_q[2] <= cfg_wdata_i;
        gvis_pkg::REG_TOL_SQ:      tol_q    <= cfg_wdata_i[gvis_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign gx = s_axis_tdata[0*G_WIDTH +: G_WIDTH];
  assign gy = s_axis_tdata[1*G_WIDTH +: G_WIDTH];
  assign gz = s_axis_tdata[2*G_WIDTH +: G_WIDTH];

  assign ld[4] = score_ready;
  assign ld[3] = !valid_q[3] || ld[4];
  assign ld[2] = !valid_q[2] || ld[3];
  assign ld[1] = !valid_q[1] || ld[2];
  assign ld[0] = !valid_q[0] || ld[1];

  assign s_axis_tready = ld[0];

  assign en.s1 = ld[0];
  assign en.s2 = ld[1];
  assign en.s3 = ld[2];
  assign en.s4 = ld[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[0]) valid_q[0] <= s_axis_tvalid;
      if (ld[1]) valid_q[1] <= valid_q[0];
      if (ld[2]) valid_q[2] <= valid_q[1];
      if (ld[3]) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) last_q[0] <= s_axis_tlast;
    if (ld[1]) last_q[1] <= last_q[0];
    if (ld[2]) last_q[2] <= last_q[1];
    if (ld[3]) last_q[3] <= last_q[2];
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    gvis_row #(
      .G_WIDTH (G_WIDTH)
    ) u_row (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (row_q[r]),
      .gx_i  (gx),
      .gy_i  (gy),
      .gz_i  (gz),
      .sq_o  (sq[r])
    );
  end

  gvis_score #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_q[3]),
    .last_i     (last_q[3]),
    .sq_i       (sq),
    .tol_i      (tol_q),
    .ready_o    (score_ready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule
